/* rtl/core/expression_token_lexer_defines.svh */
// Assertion macros shared by the expression token lexer RTL.
`ifndef EXPRESSION_TOKEN_LEXER_DEFINES_SVH
`define EXPRESSION_TOKEN_LEXER_DEFINES_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define ETL_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never hold at a clock edge outside reset.
`define ETL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

/* rtl/core/etl_pkg.sv */
// Shared types, codes and defaults of the expression token lexer.
package etl_pkg;

  localparam int NAME_LEN_DEF   = 32;
  localparam int FIFO_DEPTH_DEF = 2;

  // Token kinds.
  localparam logic [3:0] K_ERROR  = 4'd0;
  localparam logic [3:0] K_INT    = 4'd1;
  localparam logic [3:0] K_IDENT  = 4'd2;
  localparam logic [3:0] K_OP     = 4'd3;
  localparam logic [3:0] K_SEMI   = 4'd4;
  localparam logic [3:0] K_QUEST  = 4'd5;
  localparam logic [3:0] K_COLON  = 4'd6;
  localparam logic [3:0] K_ASSIGN = 4'd7;
  localparam logic [3:0] K_LPAREN = 4'd8;
  localparam logic [3:0] K_RPAREN = 4'd9;
  localparam logic [3:0] K_LBRACE = 4'd10;
  localparam logic [3:0] K_RBRACE = 4'd11;
  localparam logic [3:0] K_END    = 4'd12;

  // Operator codes.
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_EQ   = 4'd1;
  localparam logic [3:0] OP_GT   = 4'd2;
  localparam logic [3:0] OP_LT   = 4'd3;
  localparam logic [3:0] OP_ADD  = 4'd4;
  localparam logic [3:0] OP_SUB  = 4'd5;
  localparam logic [3:0] OP_MUL  = 4'd6;
  localparam logic [3:0] OP_DIV  = 4'd7;
  localparam logic [3:0] OP_MOD  = 4'd8;
  localparam logic [3:0] OP_AND  = 4'd9;
  localparam logic [3:0] OP_OR   = 4'd10;
  localparam logic [3:0] OP_NOT  = 4'd11;

  // Error causes.
  localparam logic [2:0] ERR_BADWORD  = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW = 3'd1;
  localparam logic [2:0] ERR_BAR      = 3'd2;
  localparam logic [2:0] ERR_AMP      = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd4;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_BANG   = 8'h21;

  typedef enum logic [2:0] {
    LM_IDLE, LM_NUMBER, LM_BADWORD, LM_IDENT, LM_EQ, LM_BAR, LM_AMP
  } lex_mode_t;

  typedef enum logic [1:0] {
    BK_IDLE, BK_A, BK_NAME, BK_B
  } back_state_t;

  // One queue entry: up to two result groups caused by one input item.
  // Slot a is a finished token (a whole identifier when a_name is set),
  // slot b is a single token that follows it.
  typedef struct packed {
    logic        a_valid;
    logic        a_name;
    logic [3:0]  a_kind;
    logic [3:0]  a_op;
    logic [30:0] a_ival;
    logic [2:0]  a_cause;
    logic        b_valid;
    logic [3:0]  b_kind;
    logic [3:0]  b_op;
    logic [2:0]  b_cause;
  } cmd_t;

endpackage

/* rtl/core/etl_in_if.sv */
// Input channel of the lexer: one source byte or an end mark per transfer.
interface etl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

/* rtl/core/etl_out_if.sv */
// Result channel of the lexer: one token or identifier character per transfer.
interface etl_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [3:0]  operator_code;
  logic [30:0] int_value;
  logic [7:0]  name_char;
  logic        name_end;
  logic [2:0]  error_cause;
  logic        last;

  modport source (output valid, output token_kind, output operator_code,
                  output int_value, output name_char, output name_end,
                  output error_cause, output last, input ready);
  modport sink   (input valid, input token_kind, input operator_code,
                  input int_value, input name_char, input name_end,
                  input error_cause, input last, output ready);
endinterface

/* rtl/core/etl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module etl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/etl_front.sv */
// Front end: takes source bytes, tracks the token being scanned, queues results.
module etl_front #(
  parameter int MAX_NAME_LEN = etl_pkg::NAME_LEN_DEF,
  parameter int LEN_W        = $clog2(MAX_NAME_LEN + 1),
  parameter int ADDR_W       = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  etl_in_if.sink              in_ch,
  input  logic                fifo_full,
  output logic                push,
  output etl_pkg::cmd_t       push_cmd,
  output logic [LEN_W-1:0]    push_len,
  output logic                ram_we,
  output logic [ADDR_W-1:0]   ram_waddr,
  output logic [7:0]          ram_wdata,
  input  logic                name_done,
  output logic                name_busy
);

  etl_pkg::lex_mode_t mode_r, mode_nxt;
  logic [30:0]        acc_r, acc_nxt;
  logic               ovf_r, ovf_nxt;
  logic [LEN_W-1:0]   nlen_r, nlen_nxt;
  logic               busy_r, busy_nxt;

  logic               accept;
  logic [7:0]         c;
  logic               c_digit, c_wstart, c_word, c_blank;
  logic [34:0]        acc_sum;
  logic               keep;
  etl_pkg::cmd_t      cmd;

  assign c        = in_ch.in_byte;
  assign c_digit  = (c >= 8'h30) && (c <= 8'h39);
  assign c_wstart = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
                    (c == 8'h5F);
  assign c_word   = c_wstart || c_digit;
  assign c_blank  = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  assign acc_sum  = 35'({acc_r, 3'b000}) + 35'({acc_r, 1'b0}) + 35'(c[3:0]);

  // A queued identifier owns the name RAM until its last character is sent.
  assign in_ch.ready = !busy_r && !fifo_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign name_busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= etl_pkg::LM_IDLE;
      acc_r  <= '0;
      ovf_r  <= 1'b0;
      nlen_r <= '0;
      busy_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      ovf_r  <= ovf_nxt;
      nlen_r <= nlen_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    nlen_nxt  = nlen_r;
    cmd       = '0;
    keep      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = nlen_r[ADDR_W-1:0];
    ram_wdata = c;

    if (accept) begin
      // Bytes that extend or complete the current token.
      if (!in_ch.end_of_input) begin
        unique case (mode_r)
          etl_pkg::LM_NUMBER: begin
            if (c_digit) begin
              keep = 1'b1;
              if (!ovf_r) begin
                if (acc_sum[34:31] != 4'd0) begin
                  ovf_nxt = 1'b1;
                end else begin
                  acc_nxt = acc_sum[30:0];
                end
              end
            end else if (c_wstart) begin
              keep     = 1'b1;
              mode_nxt = etl_pkg::LM_BADWORD;
            end
          end
          etl_pkg::LM_BADWORD: begin
            keep = c_word;
          end
          etl_pkg::LM_IDENT: begin
            if (c_word) begin
              keep = 1'b1;
              if (nlen_r < LEN_W'(MAX_NAME_LEN)) begin
                ram_we   = 1'b1;
                nlen_nxt = nlen_r + 1'b1;
              end
            end
          end
          etl_pkg::LM_EQ, etl_pkg::LM_BAR, etl_pkg::LM_AMP: begin
            if ((mode_r == etl_pkg::LM_EQ && c == etl_pkg::CH_EQ) ||
                (mode_r == etl_pkg::LM_BAR && c == etl_pkg::CH_BAR) ||
                (mode_r == etl_pkg::LM_AMP && c == etl_pkg::CH_AMP)) begin
              keep         = 1'b1;
              mode_nxt     = etl_pkg::LM_IDLE;
              cmd.a_valid  = 1'b1;
              cmd.a_kind   = etl_pkg::K_OP;
              cmd.a_op     = (mode_r == etl_pkg::LM_EQ)  ? etl_pkg::OP_EQ :
                             (mode_r == etl_pkg::LM_BAR) ? etl_pkg::OP_OR : etl_pkg::OP_AND;
            end
          end
          default: begin
            keep = 1'b0;
          end
        endcase
      end

      if (!keep) begin
        // Flush the pending token into slot a.
        unique case (mode_r)
          etl_pkg::LM_NUMBER: begin
            cmd.a_valid = 1'b1;
            if (ovf_r) begin
              cmd.a_kind  = etl_pkg::K_ERROR;
              cmd.a_cause = etl_pkg::ERR_OVERFLOW;
            end else begin
              cmd.a_kind = etl_pkg::K_INT;
              cmd.a_ival = acc_r;
            end
          end
          etl_pkg::LM_BADWORD: begin
            cmd.a_valid = 1'b1;
            cmd.a_kind  = etl_pkg::K_ERROR;
            cmd.a_cause = etl_pkg::ERR_BADWORD;
          end
          etl_pkg::LM_IDENT: begin
            cmd.a_valid = 1'b1;
            cmd.a_name  = 1'b1;
            cmd.a_kind  = etl_pkg::K_IDENT;
          end
          etl_pkg::LM_EQ: begin
            cmd.a_valid = 1'b1;
            cmd.a_kind  = etl_pkg::K_ASSIGN;
          end
          etl_pkg::LM_BAR: begin
            cmd.a_valid = 1'b1;
            cmd.a_kind  = etl_pkg::K_ERROR;
            cmd.a_cause = etl_pkg::ERR_BAR;
          end
          etl_pkg::LM_AMP: begin
            cmd.a_valid = 1'b1;
            cmd.a_kind  = etl_pkg::K_ERROR;
            cmd.a_cause = etl_pkg::ERR_AMP;
          end
          default: begin
            cmd.a_valid = 1'b0;
          end
        endcase
        mode_nxt = etl_pkg::LM_IDLE;
        acc_nxt  = '0;
        ovf_nxt  = 1'b0;
        nlen_nxt = '0;

        // Then start a new token, or close the stream.
        if (in_ch.end_of_input) begin
          cmd.b_valid = 1'b1;
          cmd.b_kind  = etl_pkg::K_END;
        end else if (c_blank) begin
          mode_nxt = etl_pkg::LM_IDLE;
        end else if (c_digit) begin
          mode_nxt = etl_pkg::LM_NUMBER;
          acc_nxt  = 31'(c[3:0]);
        end else if (c_wstart) begin
          mode_nxt  = etl_pkg::LM_IDENT;
          ram_we    = 1'b1;
          ram_waddr = '0;
          nlen_nxt  = LEN_W'(1);
        end else begin
          cmd.b_valid = 1'b1;
          unique case (c)
            etl_pkg::CH_EQ: begin
              cmd.b_valid = 1'b0;
              mode_nxt    = etl_pkg::LM_EQ;
            end
            etl_pkg::CH_BAR: begin
              cmd.b_valid = 1'b0;
              mode_nxt    = etl_pkg::LM_BAR;
            end
            etl_pkg::CH_AMP: begin
              cmd.b_valid = 1'b0;
              mode_nxt    = etl_pkg::LM_AMP;
            end
            etl_pkg::CH_SEMI:   cmd.b_kind = etl_pkg::K_SEMI;
            etl_pkg::CH_QUEST:  cmd.b_kind = etl_pkg::K_QUEST;
            etl_pkg::CH_COLON:  cmd.b_kind = etl_pkg::K_COLON;
            etl_pkg::CH_LPAREN: cmd.b_kind = etl_pkg::K_LPAREN;
            etl_pkg::CH_RPAREN: cmd.b_kind = etl_pkg::K_RPAREN;
            etl_pkg::CH_LBRACE: cmd.b_kind = etl_pkg::K_LBRACE;
            etl_pkg::CH_RBRACE: cmd.b_kind = etl_pkg::K_RBRACE;
            etl_pkg::CH_GT: begin
              cmd.b_kind = etl_pkg::K_OP;
              cmd.b_op   = etl_pkg::OP_GT;
            end
            etl_pkg::CH_LT: begin
              cmd.b_kind = etl_pkg::K_OP;
              cmd.b_op   = etl_pkg::OP_LT;
            end
            etl_pkg::CH_PLUS: begin
              cmd.b_kind = etl_pkg::K_OP;
              cmd.b_op   = etl_pkg::OP_ADD;
            end
            etl_pkg::CH_MINUS: begin
              cmd.b_kind = etl_pkg::K_OP;
              cmd.b_op   = etl_pkg::OP_SUB;
            end
            etl_pkg::CH_STAR: begin
              cmd.b_kind = etl_pkg::K_OP;
              cmd.b_op   = etl_pkg::OP_MUL;
            end
            etl_pkg::CH_SLASH: begin
              cmd.b_kind = etl_pkg::K_OP;
              cmd.b_op   = etl_pkg::OP_DIV;
            end
            etl_pkg::CH_PCT: begin
              cmd.b_kind = etl_pkg::K_OP;
              cmd.b_op   = etl_pkg::OP_MOD;
            end
            etl_pkg::CH_BANG: begin
              cmd.b_kind = etl_pkg::K_OP;
              cmd.b_op   = etl_pkg::OP_NOT;
            end
            default: begin
              cmd.b_kind  = etl_pkg::K_ERROR;
              cmd.b_cause = etl_pkg::ERR_UNKNOWN;
            end
          endcase
        end
      end
    end
  end

  assign push     = accept && (cmd.a_valid || cmd.b_valid);
  assign push_cmd = cmd;
  assign push_len = nlen_r;

  always_comb begin
    busy_nxt = busy_r;
    if (push && cmd.a_name) begin
      busy_nxt = 1'b1;
    end else if (name_done) begin
      busy_nxt = 1'b0;
    end
  end

endmodule

/* rtl/core/etl_cmd_fifo.sv */
// Short queue of result commands between the front and the back end.
module etl_cmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = etl_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign rdata = entry_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= wdata;
    end
  end

endmodule

/* rtl/core/etl_back.sv */
// Back end: turns queued commands into result transfers, streaming identifiers.
module etl_back #(
  parameter int LEN_W  = 6,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fifo_empty,
  input  etl_pkg::cmd_t     fifo_cmd,
  input  logic [LEN_W-1:0]  fifo_len,
  output logic              pop,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [7:0]        ram_rdata,
  output logic              name_done,
  etl_out_if.source         out_ch
);

  etl_pkg::back_state_t state_r, state_nxt;
  etl_pkg::cmd_t        cur_r, cur_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [LEN_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 dvld_r, dvld_nxt;

  logic                 oval_r, oval_nxt;
  logic [3:0]           kind_r, kind_nxt;
  logic [3:0]           op_r, op_nxt;
  logic [30:0]          ival_r, ival_nxt;
  logic [7:0]           char_r, char_nxt;
  logic                 nend_r, nend_nxt;
  logic [2:0]           cause_r, cause_nxt;
  logic                 last_r, last_nxt;

  logic                 out_free;
  logic                 load;
  logic                 fetch;
  logic                 name_final;

  assign out_free = !oval_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= etl_pkg::BK_IDLE;
      dvld_r  <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dvld_r  <= dvld_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    len_r    <= len_nxt;
    rd_idx_r <= rd_idx_nxt;
    kind_r   <= kind_nxt;
    op_r     <= op_nxt;
    ival_r   <= ival_nxt;
    char_r   <= char_nxt;
    nend_r   <= nend_nxt;
    cause_r  <= cause_nxt;
    last_r   <= last_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    len_nxt    = len_r;
    rd_idx_nxt = rd_idx_r;
    dvld_nxt   = dvld_r;
    load       = 1'b0;
    fetch      = 1'b0;
    pop        = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = rd_idx_r[ADDR_W-1:0];
    name_final = 1'b0;
    kind_nxt   = kind_r;
    op_nxt     = op_r;
    ival_nxt   = ival_r;
    char_nxt   = char_r;
    nend_nxt   = nend_r;
    cause_nxt  = cause_r;
    last_nxt   = last_r;

    unique case (state_r)
      etl_pkg::BK_IDLE: begin
        fetch = 1'b1;
      end
      etl_pkg::BK_A: begin
        if (out_free) begin
          load      = 1'b1;
          kind_nxt  = cur_r.a_kind;
          op_nxt    = cur_r.a_op;
          ival_nxt  = cur_r.a_ival;
          char_nxt  = '0;
          nend_nxt  = 1'b0;
          cause_nxt = cur_r.a_cause;
          last_nxt  = !cur_r.b_valid;
          if (cur_r.b_valid) begin
            state_nxt = etl_pkg::BK_B;
          end else begin
            fetch = 1'b1;
          end
        end
      end
      etl_pkg::BK_NAME: begin
        // The RAM output holds character rd_idx_r - 1 while dvld_r is set.
        if (dvld_r && out_free) begin
          load       = 1'b1;
          kind_nxt   = etl_pkg::K_IDENT;
          op_nxt     = etl_pkg::OP_NONE;
          ival_nxt   = '0;
          char_nxt   = ram_rdata;
          nend_nxt   = (rd_idx_r == len_r);
          cause_nxt  = '0;
          last_nxt   = (rd_idx_r == len_r) && !cur_r.b_valid;
          name_final = (rd_idx_r == len_r);
        end
        if ((rd_idx_r < len_r) && (!dvld_r || out_free)) begin
          ram_re     = 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
          dvld_nxt   = 1'b1;
        end else if (dvld_r && out_free) begin
          dvld_nxt = 1'b0;
        end
        if (name_final) begin
          if (cur_r.b_valid) begin
            state_nxt = etl_pkg::BK_B;
          end else begin
            fetch = 1'b1;
          end
        end
      end
      etl_pkg::BK_B: begin
        if (out_free) begin
          load      = 1'b1;
          kind_nxt  = cur_r.b_kind;
          op_nxt    = cur_r.b_op;
          ival_nxt  = '0;
          char_nxt  = '0;
          nend_nxt  = 1'b0;
          cause_nxt = cur_r.b_cause;
          last_nxt  = 1'b1;
          fetch     = 1'b1;
        end
      end
      default: begin
        state_nxt = etl_pkg::BK_IDLE;
      end
    endcase

    // Move straight on to the next queued command when this one is done.
    if (fetch) begin
      if (!fifo_empty) begin
        pop        = 1'b1;
        cur_nxt    = fifo_cmd;
        len_nxt    = fifo_len;
        rd_idx_nxt = '0;
        dvld_nxt   = 1'b0;
        if (!fifo_cmd.a_valid) begin
          state_nxt = etl_pkg::BK_B;
        end else if (fifo_cmd.a_name) begin
          state_nxt = etl_pkg::BK_NAME;
        end else begin
          state_nxt = etl_pkg::BK_A;
        end
      end else begin
        state_nxt = etl_pkg::BK_IDLE;
      end
    end
  end

  always_comb begin
    if (load) begin
      oval_nxt = 1'b1;
    end else if (out_ch.ready) begin
      oval_nxt = 1'b0;
    end else begin
      oval_nxt = oval_r;
    end
  end

  assign name_done            = name_final;
  assign out_ch.valid         = oval_r;
  assign out_ch.token_kind    = kind_r;
  assign out_ch.operator_code = op_r;
  assign out_ch.int_value     = ival_r;
  assign out_ch.name_char     = char_r;
  assign out_ch.name_end      = nend_r;
  assign out_ch.error_cause   = cause_r;
  assign out_ch.last          = last_r;

endmodule

/* rtl/core/expression_token_lexer.sv */
// Top level of the byte-serial expression token lexer.
//
//   channel  dir  handshake        payload
//   in_ch    in   valid / ready    in_byte, end_of_input
//   out_ch   out  valid / ready    token_kind, operator_code, int_value,
//                                  name_char, name_end, error_cause, last
//
// One input byte is taken per cycle while the command queue has room.
// Each result waits in the output register until taken; an identifier gives
// one result per character, read from the name RAM one address per cycle while the output is free.
// While an identifier waits in the queue or is being sent, no byte is taken.
// Reset is synchronous; the name RAM needs no clearing after reset.
// Either side may stall; the command queue lets the front run ahead.
module expression_token_lexer #(
  parameter int MAX_NAME_LEN = etl_pkg::NAME_LEN_DEF,
  parameter int FIFO_DEPTH   = etl_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  etl_in_if.sink     in_ch,
  etl_out_if.source  out_ch
);

  `include "expression_token_lexer_defines.svh"

  localparam int LEN_W  = $clog2(MAX_NAME_LEN + 1);
  localparam int ADDR_W = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
  localparam int CMD_W  = $bits(etl_pkg::cmd_t) + LEN_W;

  logic              push;
  etl_pkg::cmd_t     push_cmd;
  logic [LEN_W-1:0]  push_len;
  logic              pop;
  logic [CMD_W-1:0]  fifo_rdata;
  logic              fifo_empty;
  logic              fifo_full;
  etl_pkg::cmd_t     fifo_cmd;
  logic [LEN_W-1:0]  fifo_len;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic              name_done;
  logic              name_busy;

  etl_front #(
    .MAX_NAME_LEN (MAX_NAME_LEN),
    .LEN_W        (LEN_W),
    .ADDR_W       (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .fifo_full (fifo_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_len  (push_len),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .name_done (name_done),
    .name_busy (name_busy)
  );

  etl_cmd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({push_cmd, push_len}),
    .pop   (pop),
    .rdata (fifo_rdata),
    .empty (fifo_empty),
    .full  (fifo_full)
  );

  assign fifo_cmd = fifo_rdata[CMD_W-1:LEN_W];
  assign fifo_len = fifo_rdata[LEN_W-1:0];

  etl_ram #(
    .WIDTH (8),
    .DEPTH (MAX_NAME_LEN)
  ) u_name_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  etl_back #(
    .LEN_W  (LEN_W),
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .fifo_cmd   (fifo_cmd),
    .fifo_len   (fifo_len),
    .pop        (pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .name_done  (name_done),
    .out_ch     (out_ch)
  );

  // The name RAM is never rewritten while a queued identifier still reads it.
  `ETL_ASSERT_IMPLY(a_no_write_busy, ram_we, !name_busy, "name RAM written while in use")
  // The back end only finishes an identifier that the front end handed over.
  `ETL_ASSERT_IMPLY(a_done_busy, name_done, name_busy, "identifier finished while not queued")
  `ETL_ASSERT_NEVER(a_no_overrun, push && fifo_full && !pop, "command queue overrun")
  // Only the final character of an identifier may close an item's results.
  `ETL_ASSERT_IMPLY(a_ident_last,
    out_ch.valid && out_ch.token_kind == etl_pkg::K_IDENT && !out_ch.name_end,
    !out_ch.last, "item closed inside an identifier")

endmodule

/* bench/tb_expression_token_lexer.sv */
// Self-checking bench for the expression token lexer: source streams in, tokens checked.
module tb_expression_token_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NAME_MAX    = etl_pkg::NAME_LEN_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_WAIT  = 20;

  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;
  localparam logic [7:0] CH_LOWER_LO = 8'h61;
  localparam logic [7:0] CH_LOWER_HI = 8'h7A;
  localparam logic [7:0] CH_UPPER_LO = 8'h41;
  localparam logic [7:0] CH_UPPER_HI = 8'h5A;
  localparam logic [7:0] CH_UNDER    = 8'h5F;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  op;
    logic [30:0] ival;
    logic [7:0]  ch;
    logic        nend;
    logic [2:0]  cause;
    logic        last;
  } token_t;

  logic clk;
  logic rst_n;

  etl_in_if  in_ch ();
  etl_out_if out_ch ();

  expression_token_lexer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Lexer state as the bench tracks it, and the tokens it still waits for.
  token_t             pending_tokens[$];
  etl_pkg::lex_mode_t scan_mode;
  logic [31:0]        num_value;
  logic               num_ovf;
  logic [7:0]         word_buf [NAME_MAX];
  int unsigned        word_len;

  int  cycle_count;
  int  items_sent;
  int  tokens_checked;
  int  mismatches;
  int  held_cycles;
  bit  idle_on;
  bit  hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_DIGIT_LO && c <= CH_DIGIT_HI;
  endfunction

  function automatic bit is_word_start(logic [7:0] c);
    return (c >= CH_LOWER_LO && c <= CH_LOWER_HI) ||
           (c >= CH_UPPER_LO && c <= CH_UPPER_HI) || c == CH_UNDER;
  endfunction

  function automatic bit is_word(logic [7:0] c);
    return is_word_start(c) || is_digit(c);
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void push_token(logic [3:0] kind, logic [3:0] op, logic [30:0] ival,
                                     logic [7:0] ch, logic nend, logic [2:0] cause);
    token_t t;
    t = '{kind: kind, op: op, ival: ival, ch: ch, nend: nend, cause: cause, last: 1'b0};
    pending_tokens.push_back(t);
  endfunction

  function automatic void push_simple(logic [3:0] kind, logic [3:0] op);
    push_token(kind, op, 31'd0, 8'd0, 1'b0, etl_pkg::ERR_BADWORD);
  endfunction

  function automatic void push_error(logic [2:0] cause);
    push_token(etl_pkg::K_ERROR, etl_pkg::OP_NONE, 31'd0, 8'd0, 1'b0, cause);
  endfunction

  // Emit whatever token is still open and go back to idle.
  function automatic void flush_token();
    case (scan_mode)
      etl_pkg::LM_NUMBER: begin
        if (num_ovf) push_error(etl_pkg::ERR_OVERFLOW);
        else push_token(etl_pkg::K_INT, etl_pkg::OP_NONE, num_value[30:0], 8'd0, 1'b0,
                        etl_pkg::ERR_BADWORD);
      end
      etl_pkg::LM_BADWORD: push_error(etl_pkg::ERR_BADWORD);
      etl_pkg::LM_IDENT: begin
        for (int i = 0; i < int'(word_len); i++)
          push_token(etl_pkg::K_IDENT, etl_pkg::OP_NONE, 31'd0, word_buf[i],
                     (i + 1 == int'(word_len)), etl_pkg::ERR_BADWORD);
      end
      etl_pkg::LM_EQ:  push_simple(etl_pkg::K_ASSIGN, etl_pkg::OP_NONE);
      etl_pkg::LM_BAR: push_error(etl_pkg::ERR_BAR);
      etl_pkg::LM_AMP: push_error(etl_pkg::ERR_AMP);
      default: ;
    endcase
    scan_mode = etl_pkg::LM_IDLE;
    num_value = '0;
    num_ovf   = 1'b0;
    word_len  = 0;
  endfunction

  function automatic void begin_token(logic [7:0] c);
    scan_mode = etl_pkg::LM_IDLE;
    if (is_blank(c)) return;
    if (is_digit(c)) begin
      scan_mode = etl_pkg::LM_NUMBER;
      num_value = 32'(c - CH_DIGIT_LO);
      num_ovf   = 1'b0;
      return;
    end
    if (is_word_start(c)) begin
      scan_mode   = etl_pkg::LM_IDENT;
      word_buf[0] = c;
      word_len    = 1;
      return;
    end
    case (c)
      etl_pkg::CH_EQ:     scan_mode = etl_pkg::LM_EQ;
      etl_pkg::CH_BAR:    scan_mode = etl_pkg::LM_BAR;
      etl_pkg::CH_AMP:    scan_mode = etl_pkg::LM_AMP;
      etl_pkg::CH_SEMI:   push_simple(etl_pkg::K_SEMI, etl_pkg::OP_NONE);
      etl_pkg::CH_QUEST:  push_simple(etl_pkg::K_QUEST, etl_pkg::OP_NONE);
      etl_pkg::CH_COLON:  push_simple(etl_pkg::K_COLON, etl_pkg::OP_NONE);
      etl_pkg::CH_LPAREN: push_simple(etl_pkg::K_LPAREN, etl_pkg::OP_NONE);
      etl_pkg::CH_RPAREN: push_simple(etl_pkg::K_RPAREN, etl_pkg::OP_NONE);
      etl_pkg::CH_LBRACE: push_simple(etl_pkg::K_LBRACE, etl_pkg::OP_NONE);
      etl_pkg::CH_RBRACE: push_simple(etl_pkg::K_RBRACE, etl_pkg::OP_NONE);
      etl_pkg::CH_GT:     push_simple(etl_pkg::K_OP, etl_pkg::OP_GT);
      etl_pkg::CH_LT:     push_simple(etl_pkg::K_OP, etl_pkg::OP_LT);
      etl_pkg::CH_PLUS:   push_simple(etl_pkg::K_OP, etl_pkg::OP_ADD);
      etl_pkg::CH_MINUS:  push_simple(etl_pkg::K_OP, etl_pkg::OP_SUB);
      etl_pkg::CH_STAR:   push_simple(etl_pkg::K_OP, etl_pkg::OP_MUL);
      etl_pkg::CH_SLASH:  push_simple(etl_pkg::K_OP, etl_pkg::OP_DIV);
      etl_pkg::CH_PCT:    push_simple(etl_pkg::K_OP, etl_pkg::OP_MOD);
      etl_pkg::CH_BANG:   push_simple(etl_pkg::K_OP, etl_pkg::OP_NOT);
      default:            push_error(etl_pkg::ERR_UNKNOWN);
    endcase
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    logic [63:0] next_val;
    case (scan_mode)
      etl_pkg::LM_NUMBER: begin
        if (is_digit(c)) begin
          if (!num_ovf) begin
            next_val = 64'(num_value) * 64'd10 + 64'(c - CH_DIGIT_LO);
            if (next_val > 64'd2147483647) num_ovf = 1'b1;
            else num_value = next_val[31:0];
          end
          return;
        end
        if (is_word_start(c)) begin
          scan_mode = etl_pkg::LM_BADWORD;
          return;
        end
      end
      etl_pkg::LM_BADWORD: if (is_word(c)) return;
      etl_pkg::LM_IDENT: begin
        if (is_word(c)) begin
          // Characters past the name limit are consumed and dropped.
          if (word_len < NAME_MAX) begin
            word_buf[word_len] = c;
            word_len++;
          end
          return;
        end
      end
      etl_pkg::LM_EQ: begin
        if (c == etl_pkg::CH_EQ) begin
          push_simple(etl_pkg::K_OP, etl_pkg::OP_EQ);
          scan_mode = etl_pkg::LM_IDLE;
          return;
        end
      end
      etl_pkg::LM_BAR: begin
        if (c == etl_pkg::CH_BAR) begin
          push_simple(etl_pkg::K_OP, etl_pkg::OP_OR);
          scan_mode = etl_pkg::LM_IDLE;
          return;
        end
      end
      etl_pkg::LM_AMP: begin
        if (c == etl_pkg::CH_AMP) begin
          push_simple(etl_pkg::K_OP, etl_pkg::OP_AND);
          scan_mode = etl_pkg::LM_IDLE;
          return;
        end
      end
      default: ;
    endcase
    flush_token();
    begin_token(c);
  endfunction

  // Work out the tokens one accepted transfer causes and mark the final one.
  function automatic void lex_item_tokens(logic [7:0] c, logic eoi);
    int     first;
    token_t t;
    first = pending_tokens.size();
    if (eoi) begin
      flush_token();
      push_simple(etl_pkg::K_END, etl_pkg::OP_NONE);
    end else begin
      scan_byte(c);
    end
    if (pending_tokens.size() > first) begin
      t = pending_tokens.pop_back();
      t.last = 1'b1;
      pending_tokens.push_back(t);
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(logic [7:0] c, logic eoi);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.in_byte      = c;
    in_ch.end_of_input = eoi;
    // Ready only moves at rising edges, so it is settled at the falling edge.
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    lex_item_tokens(c, eoi);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] rand_word_start();
    int unsigned k;
    k = $urandom_range(0, 52);
    if (k < 26) return CH_LOWER_LO + 8'(k);
    if (k < 52) return CH_UPPER_LO + 8'(k - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_word_char();
    if ($urandom_range(0, 5) == 0) return CH_DIGIT_LO + 8'($urandom_range(0, 9));
    return rand_word_start();
  endfunction

  // One lexeme of the source language, mostly well formed, sometimes broken.
  task automatic send_random_lexeme();
    string       op_texts[19];
    logic [7:0]  blanks[6];
    int unsigned pick;
    int unsigned n;
    op_texts = '{"==", "&&", "||", "=", ";", "?", ":", "(", ")", "{", "}",
                 ">", "<", "+", "-", "*", "/", "%", "!"};
    blanks   = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      case ($urandom_range(0, 5))
        0: send_text("0");
        1: send_text("2147483647");
        2: send_text("2147483648");
        3: begin
          n = $urandom_range(1, 13);
          repeat (n) send_item(CH_DIGIT_LO + 8'($urandom_range(0, 9)), 1'b0);
        end
        default: send_text($sformatf("%0d", $urandom_range(0, 999)));
      endcase
    end else if (pick < 44) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
      send_item(rand_word_start(), 1'b0);
      repeat (n - 1) send_item(rand_word_char(), 1'b0);
    end else if (pick < 50) begin
      repeat ($urandom_range(1, 3)) send_item(CH_DIGIT_LO + 8'($urandom_range(0, 9)), 1'b0);
      send_item(rand_word_start(), 1'b0);
      repeat ($urandom_range(0, 3)) send_item(rand_word_char(), 1'b0);
    end else if (pick < 72) begin
      send_text(op_texts[$urandom_range(0, 18)]);
    end else if (pick < 84) begin
      send_item(blanks[$urandom_range(0, 5)], 1'b0);
    end else if (pick < 90) begin
      send_item(($urandom_range(0, 1) != 0) ? etl_pkg::CH_BAR : etl_pkg::CH_AMP, 1'b0);
    end else if (pick < 96) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_end();
    end
    if ($urandom_range(0, 1) == 0) send_item(CH_SPACE, 1'b0);
  endtask

  task automatic test_punctuation_and_operators();
    // A trailing lone = is flushed by the end mark as an assignment token.
    send_text(";?:(){}><+-*/%!==&&||=");
    send_end();
  endtask

  task automatic test_error_cases();
    send_item(etl_pkg::CH_BAR, 1'b0);
    send_item(etl_pkg::CH_AMP, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b0);
    send_text("9a_");
    send_item(CH_TAB, 1'b0);
    send_end();
  endtask

  task automatic test_random_stream(int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) send_random_lexeme();
  endtask

  task automatic test_receiver_hold();
    hold_request = 1'b1;
    send_text("alpha beta_gamma x1 ");
    test_random_stream(15);
    while (hold_request) @(negedge clk);
  endtask

  task automatic test_without_idling();
    idle_on = 1'b0;
    test_random_stream(30);
    send_end();
  endtask

  // Result side: random stalls, plus one long hold on request.
  initial begin
    out_ch.ready = 1'b0;
    held_cycles  = 0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        held_cycles += HOLD_CYCLES;
        hold_request = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    token_t seen;
    token_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = '{kind: out_ch.token_kind, op: out_ch.operator_code, ival: out_ch.int_value,
               ch: out_ch.name_char, nend: out_ch.name_end, cause: out_ch.error_cause,
               last: out_ch.last};
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] token with none outstanding: kind=%0d op=%0d val=%0d ch=%02h",
                   $realtime, seen.kind, seen.op, seen.ival, seen.ch);
      end else begin
        want = pending_tokens.pop_front();
        tokens_checked++;
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] token mismatch: expected kind=%0d op=%0d val=%0d ch=%02h ",
                      "end=%0d cause=%0d last=%0d, got kind=%0d op=%0d val=%0d ch=%02h ",
                      "end=%0d cause=%0d last=%0d"}, $realtime,
                     want.kind, want.op, want.ival, want.ch, want.nend, want.cause,
                     want.last, seen.kind, seen.op, seen.ival, seen.ch, seen.nend,
                     seen.cause, seen.last);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d tokens outstanding.",
             cycle_count, pending_tokens.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = 8'd0;
    in_ch.end_of_input = 1'b0;
    idle_on            = 1'b1;
    hold_request       = 1'b0;
    items_sent         = 0;
    tokens_checked     = 0;
    mismatches         = 0;
    scan_mode          = etl_pkg::LM_IDLE;
    num_value          = '0;
    num_ovf            = 1'b0;
    word_len           = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_punctuation_and_operators();
    test_error_cases();
    test_random_stream(50);
    test_receiver_hold();
    test_without_idling();

    in_ch.valid = 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_tokens.size() != 0) mismatches++;

    $display("Lexed %0d source transfers into %0d checked tokens, %0d mismatched,",
             items_sent, tokens_checked, mismatches);
    $display("with random stalls on both sides and one %0d-cycle receiver hold.",
             held_cycles);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
